/* rtl/core/bsf_pkg.sv */
// Shared constants, codes and types of the broadcast signal filter.
`default_nettype none

package bsf_pkg;

	localparam int SLOT_COUNT    = 4;
	localparam int PAYLOAD_BYTES = 23;
	localparam int HASH_REGS     = 4;
	localparam int MIN_PACKET    = 8;
	localparam int LEN_W         = 5;

	localparam logic [5:0] POS_MAX  = 6'd63;
	localparam logic [7:0] WRAP_OLD = 8'd192;
	localparam logic [7:0] WRAP_NEW = 8'd64;

	localparam logic [2:0] REG_ACTIVE = 3'd0;
	localparam logic [2:0] REG_HASH0  = 3'd1;

	typedef enum logic [1:0] {
		KIND_RX   = 2'd0,
		KIND_READ = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_SEND = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STS_DATA      = 3'd0,
		STS_IGNORED   = 3'd1,
		STS_PROCESSED = 3'd2,
		STS_BAD_SLOT  = 3'd3,
		STS_TOO_LONG  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_MATCH = 5'b00100,
		ST_COPY  = 5'b01000,
		ST_SEND  = 5'b10000
	} state_t;

	// Frame header bytes, in order of transmission
	function automatic logic [7:0] head_byte(input logic [1:0] i);
		logic [7:0] b;
		case (i)
			2'd0: b = 8'd255;
			2'd1: b = 8'd3;
			2'd2: b = 8'd151;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bsf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 23
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/broadcast_signal_filter.sv */
// Broadcast signal filter: slot table, receive filter and frame transmitter.
//
// An item is taken when start is high and busy is low; each result appears for one
// cycle with strobe high and must be taken then. A non-final receive byte and a
// transmit load give no result. A rejected packet end, a bad slot and a too-long
// send are answered from the idle state. A slot read returns the registered payload
// memory data from the read state. An accepted packet end passes through the match
// state for the hash and counter match, then the copy state for each updated slot,
// where the staged payload is copied one byte a cycle into the payload memory; the
// last write lands as the copy state is left. A send emits one frame byte a cycle,
// the payload bytes streamed from the transmit staging memory. Payload and staging
// stores are not cleared at reset.
`default_nettype none

module broadcast_signal_filter #(
	parameter int SLOT_COUNT    = bsf_pkg::SLOT_COUNT,
	parameter int PAYLOAD_BYTES = bsf_pkg::PAYLOAD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        packet_end,
	input  logic [1:0]  slot,
	input  logic [4:0]  byte_index,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        frame_last,
	output logic [2:0]  status,
	output logic [3:0]  update_mask,
	output logic [4:0]  stored_size,
	output logic [7:0]  stored_count
);

	localparam int LEN_W     = bsf_pkg::LEN_W;
	localparam int SLOT_IW   = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
	localparam int PAY_DEPTH = SLOT_COUNT * PAYLOAD_BYTES;
	localparam int PAY_AW    = PAY_DEPTH > 1 ? $clog2(PAY_DEPTH) : 1;
	localparam int STG_AW    = PAYLOAD_BYTES > 1 ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [6:0]       PB7      = 7'(PAYLOAD_BYTES);
	localparam logic [LEN_W-1:0] PB_LEN   = LEN_W'(PAYLOAD_BYTES);
	localparam logic [2:0]       SLOTS3   = 3'(SLOT_COUNT);

	// configuration
	logic [2:0]  active_q;
	logic [31:0] hash_q [bsf_pkg::HASH_REGS];

	// control state
	bsf_pkg::state_t state_q;
	logic [5:0]       rx_pos_q;
	logic             rx_hdr_q;
	logic [7:0]       rx_seq_q;
	logic [31:0]      rx_ident_q;
	logic [LEN_W-1:0] tx_len_q;
	logic [7:0]       slot_seq_q [SLOT_COUNT];
	logic [LEN_W-1:0] slot_len_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] copy_mask_q;
	logic [LEN_W-1:0] copy_size_q;
	logic [LEN_W-1:0] copy_i_q;
	logic             copy_we_s1;
	logic [PAY_AW-1:0] copy_waddr_s1;
	logic [SLOT_IW-1:0] op_slot_q;
	logic             rd_en_q;
	logic [LEN_W-1:0] send_len_q;
	logic [31:0]      send_hash_q;
	logic [LEN_W-1:0] k_q;

	// memory ports
	logic              rx_we;
	logic [STG_AW-1:0] rx_waddr, rx_raddr;
	logic [7:0]        rx_rdata;
	logic              tx_we;
	logic [STG_AW-1:0] tx_waddr, tx_raddr;
	logic [7:0]        tx_rdata;
	logic              pay_we, send_we;
	logic [PAY_AW-1:0] pay_waddr, pay_raddr, send_waddr;
	logic [7:0]        pay_wdata, pay_rdata;

	// decode
	logic               accept;
	logic [2:0]         used;
	logic               slot_ok;
	logic [SLOT_IW-1:0] sidx;
	logic               rd_en;
	logic               hdr_next;
	logic [7:0]         seq_next;
	logic [31:0]        ident_next;
	logic               rx_ok;
	logic [LEN_W-1:0]   rx_size;
	logic [5:0]         pos_m7;
	logic [SLOT_COUNT-1:0] match;
	logic [SLOT_IW-1:0] cur_slot;
	logic               copy_last;
	logic               send_last;

	// result
	logic                  res_vld;
	logic [7:0]            res_byte;
	logic                  res_last;
	bsf_pkg::status_t      res_status;
	logic [3:0]            res_mask;
	logic [LEN_W-1:0]      res_size;
	logic [7:0]            res_count;

	bsf_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_rx_stage (
		.clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(data_byte),
		.raddr(rx_raddr), .rdata(rx_rdata)
	);

	bsf_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_tx_stage (
		.clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(data_byte),
		.raddr(tx_raddr), .rdata(tx_rdata)
	);

	bsf_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_payload (
		.clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
		.raddr(pay_raddr), .rdata(pay_rdata)
	);

	assign busy   = state_q != bsf_pkg::ST_IDLE;
	assign accept = start && !busy;
	assign used   = active_q < SLOTS3 ? active_q : SLOTS3;
	assign slot_ok = {1'b0, slot} < used;
	assign sidx   = SLOT_IW'(slot);
	assign rd_en  = byte_index < slot_len_q[sidx] && byte_index < PB_LEN;

	// copy and send writes never overlap
	assign pay_we    = copy_we_s1 || send_we;
	assign pay_waddr = copy_we_s1 ? copy_waddr_s1 : send_waddr;
	assign pay_wdata = copy_we_s1 ? rx_rdata : tx_rdata;

	// receive byte decode
	always_comb begin
		hdr_next   = rx_hdr_q;
		seq_next   = rx_seq_q;
		ident_next = rx_ident_q;
		if (rx_pos_q < 6'd3) begin
			if (data_byte != bsf_pkg::head_byte(rx_pos_q[1:0])) begin
				hdr_next = 1'b0;
			end
		end else if (rx_pos_q == 6'd3) begin
			seq_next = data_byte;
		end else if (rx_pos_q < 6'(bsf_pkg::MIN_PACKET)) begin
			ident_next = rx_ident_q | (32'(data_byte) << {rx_pos_q[1:0], 3'b000});
		end
		rx_ok   = hdr_next && rx_pos_q >= 6'd7;
		pos_m7  = rx_pos_q - 6'd7;
		rx_size = {1'b0, pos_m7} > PB7 ? PB_LEN : LEN_W'(pos_m7);
	end

	// slot match on the finished packet
	always_comb begin
		logic [31:0] hv;
		logic [7:0]  old;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			hv  = (s < bsf_pkg::HASH_REGS) ? hash_q[s % bsf_pkg::HASH_REGS] : 32'd0;
			old = slot_seq_q[s];
			match[s] = 3'(s) < used && hv == rx_ident_q &&
				(old < rx_seq_q || (old > bsf_pkg::WRAP_OLD && rx_seq_q <= bsf_pkg::WRAP_NEW));
		end
		for (int i = 0; i < 4; i++) begin
			res_mask[i] = (i < SLOT_COUNT) ? match[i % SLOT_COUNT] : 1'b0;
		end
	end

	always_comb begin
		cur_slot = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (copy_mask_q[s]) begin
				cur_slot = SLOT_IW'(s);
			end
		end
	end

	assign copy_last = copy_i_q == copy_size_q - LEN_W'(1);
	assign send_last = k_q == send_len_q + LEN_W'(bsf_pkg::MIN_PACKET - 1);

	always_comb begin
		res_vld    = 1'b0;
		res_byte   = 8'd0;
		res_last   = 1'b0;
		res_status = bsf_pkg::STS_DATA;
		res_size   = '0;
		res_count  = 8'd0;
		rx_we      = 1'b0;
		rx_waddr   = STG_AW'({1'b0, rx_pos_q} - 7'(bsf_pkg::MIN_PACKET));
		rx_raddr   = STG_AW'(copy_i_q);
		tx_we      = 1'b0;
		tx_waddr   = STG_AW'(tx_len_q);
		tx_raddr   = STG_AW'(k_q - LEN_W'(bsf_pkg::MIN_PACKET - 1));
		pay_raddr  = '0;
		send_we    = 1'b0;
		send_waddr = PAY_AW'(int'(op_slot_q) * PAYLOAD_BYTES + int'(k_q)
			- bsf_pkg::MIN_PACKET);
		case (state_q)
			bsf_pkg::ST_IDLE: begin
				if (accept) begin
					case (bsf_pkg::kind_t'(kind))
						bsf_pkg::KIND_RX: begin
							rx_we = rx_pos_q >= 6'(bsf_pkg::MIN_PACKET) &&
								({1'b0, rx_pos_q} - 7'(bsf_pkg::MIN_PACKET)) < PB7;
							if (packet_end && !rx_ok) begin
								res_vld    = 1'b1;
								res_status = bsf_pkg::STS_IGNORED;
							end
						end
						bsf_pkg::KIND_READ: begin
							if (!slot_ok) begin
								res_vld    = 1'b1;
								res_status = bsf_pkg::STS_BAD_SLOT;
							end else if (rd_en) begin
								pay_raddr = PAY_AW'(int'(sidx) * PAYLOAD_BYTES + int'(byte_index));
							end
						end
						bsf_pkg::KIND_LOAD: begin
							tx_we = tx_len_q < PB_LEN;
						end
						bsf_pkg::KIND_SEND: begin
							if (!slot_ok) begin
								res_vld    = 1'b1;
								res_status = bsf_pkg::STS_BAD_SLOT;
							end else if (tx_len_q > PB_LEN) begin
								res_vld    = 1'b1;
								res_status = bsf_pkg::STS_TOO_LONG;
								res_size   = slot_len_q[sidx];
								res_count  = slot_seq_q[sidx];
							end
						end
						default: begin
						end
					endcase
				end
			end
			bsf_pkg::ST_READ: begin
				res_vld   = 1'b1;
				res_byte  = rd_en_q ? pay_rdata : 8'd0;
				res_size  = slot_len_q[op_slot_q];
				res_count = slot_seq_q[op_slot_q];
			end
			bsf_pkg::ST_MATCH: begin
				res_vld    = 1'b1;
				res_status = bsf_pkg::STS_PROCESSED;
			end
			bsf_pkg::ST_COPY: begin
			end
			bsf_pkg::ST_SEND: begin
				res_vld   = 1'b1;
				res_last  = send_last;
				res_size  = send_len_q;
				res_count = slot_seq_q[op_slot_q];
				if (k_q < LEN_W'(3)) begin
					res_byte = bsf_pkg::head_byte(k_q[1:0]);
				end else if (k_q == LEN_W'(3)) begin
					res_byte = slot_seq_q[op_slot_q];
				end else if (k_q < LEN_W'(bsf_pkg::MIN_PACKET)) begin
					res_byte = 8'(send_hash_q >> {k_q[1:0], 3'b000});
				end else begin
					res_byte = tx_rdata;
					send_we  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 3'd0;
			for (int i = 0; i < bsf_pkg::HASH_REGS; i++) begin
				hash_q[i] <= 32'd0;
			end
		end else if (wr_en) begin
			if (wr_index == bsf_pkg::REG_ACTIVE) begin
				active_q <= wr_data[2:0];
			end else if (wr_index >= bsf_pkg::REG_HASH0 &&
				wr_index < bsf_pkg::REG_HASH0 + 3'(bsf_pkg::HASH_REGS)) begin
				hash_q[2'(wr_index - bsf_pkg::REG_HASH0)] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsf_pkg::ST_IDLE;
			rx_pos_q    <= 6'd0;
			rx_hdr_q    <= 1'b1;
			rx_seq_q    <= 8'd0;
			rx_ident_q  <= 32'd0;
			tx_len_q    <= '0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				slot_seq_q[s] <= 8'd0;
				slot_len_q[s] <= '0;
			end
			copy_mask_q <= '0;
			copy_size_q <= '0;
			copy_i_q    <= '0;
			copy_we_s1  <= 1'b0;
			op_slot_q   <= '0;
			rd_en_q     <= 1'b0;
			send_len_q  <= '0;
			k_q         <= '0;
			strobe      <= 1'b0;
		end else begin
			strobe     <= res_vld;
			copy_we_s1 <= 1'b0;
			case (state_q)
				bsf_pkg::ST_IDLE: begin
					if (accept) begin
						case (bsf_pkg::kind_t'(kind))
							bsf_pkg::KIND_RX: begin
								if (!packet_end) begin
									rx_hdr_q   <= hdr_next;
									rx_seq_q   <= seq_next;
									rx_ident_q <= ident_next;
									if (rx_pos_q < bsf_pkg::POS_MAX) begin
										rx_pos_q <= rx_pos_q + 6'd1;
									end
								end else if (!rx_ok) begin
									rx_pos_q   <= 6'd0;
									rx_hdr_q   <= 1'b1;
									rx_seq_q   <= 8'd0;
									rx_ident_q <= 32'd0;
								end else begin
									// hold the packet fields for the match cycle
									rx_seq_q    <= seq_next;
									rx_ident_q  <= ident_next;
									copy_size_q <= rx_size;
									state_q     <= bsf_pkg::ST_MATCH;
								end
							end
							bsf_pkg::KIND_READ: begin
								if (slot_ok) begin
									op_slot_q <= sidx;
									rd_en_q   <= rd_en;
									state_q   <= bsf_pkg::ST_READ;
								end
							end
							bsf_pkg::KIND_LOAD: begin
								if (tx_len_q <= PB_LEN) begin
									tx_len_q <= tx_len_q + LEN_W'(1);
								end
							end
							bsf_pkg::KIND_SEND: begin
								tx_len_q <= '0;
								if (slot_ok && tx_len_q <= PB_LEN) begin
									slot_len_q[sidx] <= tx_len_q;
									slot_seq_q[sidx] <= slot_seq_q[sidx] + 8'd1;
									op_slot_q   <= sidx;
									send_len_q  <= tx_len_q;
									send_hash_q <= hash_q[slot];
									k_q         <= '0;
									state_q     <= bsf_pkg::ST_SEND;
								end
							end
							default: begin
							end
						endcase
					end
				end
				bsf_pkg::ST_READ: begin
					state_q <= bsf_pkg::ST_IDLE;
				end
				bsf_pkg::ST_MATCH: begin
					for (int s = 0; s < SLOT_COUNT; s++) begin
						if (match[s]) begin
							slot_len_q[s] <= copy_size_q;
							slot_seq_q[s] <= rx_seq_q;
						end
					end
					rx_pos_q    <= 6'd0;
					rx_hdr_q    <= 1'b1;
					rx_seq_q    <= 8'd0;
					rx_ident_q  <= 32'd0;
					copy_mask_q <= match;
					copy_i_q    <= '0;
					if (match == '0 || copy_size_q == '0) begin
						state_q <= bsf_pkg::ST_IDLE;
					end else begin
						state_q <= bsf_pkg::ST_COPY;
					end
				end
				bsf_pkg::ST_COPY: begin
					// last write of the sweep lands at the edge that leaves this state
					if (copy_mask_q == '0) begin
						state_q <= bsf_pkg::ST_IDLE;
					end else begin
						copy_we_s1    <= 1'b1;
						copy_waddr_s1 <= PAY_AW'(int'(cur_slot) * PAYLOAD_BYTES + int'(copy_i_q));
						if (copy_last) begin
							copy_mask_q[cur_slot] <= 1'b0;
							copy_i_q <= '0;
						end else begin
							copy_i_q <= copy_i_q + LEN_W'(1);
						end
					end
				end
				bsf_pkg::ST_SEND: begin
					if (send_last) begin
						state_q <= bsf_pkg::ST_IDLE;
					end else begin
						k_q <= k_q + LEN_W'(1);
					end
				end
				default: begin
					state_q <= bsf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		out_byte     <= res_byte;
		frame_last   <= res_last;
		status       <= res_status;
		update_mask  <= (state_q == bsf_pkg::ST_MATCH) ? res_mask : 4'd0;
		stored_size  <= res_size;
		stored_count <= res_count;
	end

endmodule

`default_nettype wire

/* dv/bsf_checker.sv */
// Checker for the broadcast signal filter: slot table predictor and result word comparison.
module bsf_checker
	import bsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        packet_end,
	input  logic [1:0]  slot,
	input  logic [4:0]  byte_index,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        strobe,
	input  logic [7:0]  out_byte,
	input  logic        frame_last,
	input  logic [2:0]  status,
	input  logic [3:0]  update_mask,
	input  logic [4:0]  stored_size,
	input  logic [7:0]  stored_count,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		status_t    sts;
		logic [3:0] mask;
		logic [4:0] len;
		logic [7:0] count;
	} word_t;

	// Header bytes in order of arrival, lowest byte first
	localparam logic [23:0] FRAME_HEAD = {8'd151, 8'd3, 8'd255};

	logic [2:0]  active_q;
	logic [31:0] hash_q [HASH_REGS];

	logic [5:0]  rx_pos;
	logic        rx_hdr_ok;
	logic [7:0]  rx_seq;
	logic [31:0] rx_id;
	logic [7:0]  rx_buf [PAYLOAD_BYTES];
	logic [7:0]  tx_buf [PAYLOAD_BYTES];
	logic [4:0]  tx_len;

	logic [7:0]  slot_seq [SLOT_COUNT];
	logic [4:0]  slot_len [SLOT_COUNT];
	logic [7:0]  slot_data [SLOT_COUNT][PAYLOAD_BYTES];

	word_t awaited_words [$];
	word_t got, want;
	int    errs;

	function automatic int used_slots();
		return (active_q < SLOT_COUNT) ? int'(active_q) : SLOT_COUNT;
	endfunction

	task automatic push_word(input logic [7:0] value, input logic last, input status_t sts,
			input logic [3:0] mask, input logic [4:0] len, input logic [7:0] count);
		word_t w;
		w.value = value;
		w.last  = last;
		w.sts   = sts;
		w.mask  = mask;
		w.len   = len;
		w.count = count;
		awaited_words.push_back(w);
	endtask

	task automatic clear_rx();
		rx_pos    = '0;
		rx_hdr_ok = 1'b1;
		rx_seq    = '0;
		rx_id     = '0;
	endtask

	task automatic take_rx(input logic [7:0] b, input logic eop);
		logic [5:0] p;
		logic [6:0] total;
		logic [4:0] n;
		logic [3:0] hits;
		logic [7:0] old;
		p = rx_pos;
		if (p < 3) begin
			if (b != FRAME_HEAD[8*p +: 8])
				rx_hdr_ok = 1'b0;
		end else if (p == 3) begin
			rx_seq = b;
		end else if (p < MIN_PACKET) begin
			rx_id[8*(p-4) +: 8] = b;
		end else if (p - MIN_PACKET < PAYLOAD_BYTES) begin
			rx_buf[5'(p - MIN_PACKET)] = b;
		end
		// position saturates, payload past the staging depth is dropped
		if (rx_pos < POS_MAX)
			rx_pos = rx_pos + 6'd1;
		if (eop) begin
			total = {1'b0, p} + 7'd1;
			if (!rx_hdr_ok || total < MIN_PACKET) begin
				push_word(8'd0, 1'b0, STS_IGNORED, 4'd0, 5'd0, 8'd0);
			end else begin
				n = 5'((total - MIN_PACKET > PAYLOAD_BYTES) ? PAYLOAD_BYTES
					: total - MIN_PACKET);
				hits = '0;
				for (int s = 0; s < used_slots(); s++) begin
					old = slot_seq[s];
					// newer counter, or wrapped from high to low
					if (hash_q[s] == rx_id &&
							(old < rx_seq || (old > WRAP_OLD && rx_seq <= WRAP_NEW))) begin
						for (int i = 0; i < n; i++)
							slot_data[s][i] = rx_buf[i];
						slot_len[s] = n;
						slot_seq[s] = rx_seq;
						hits[s]     = 1'b1;
					end
				end
				push_word(8'd0, 1'b0, STS_PROCESSED, hits, 5'd0, 8'd0);
			end
			clear_rx();
		end
	endtask

	task automatic take_read(input logic [1:0] s, input logic [4:0] idx);
		logic [7:0] v;
		if (s >= used_slots()) begin
			push_word(8'd0, 1'b0, STS_BAD_SLOT, 4'd0, 5'd0, 8'd0);
		end else begin
			v = '0;
			if (idx < slot_len[s] && idx < PAYLOAD_BYTES)
				v = slot_data[s][idx];
			push_word(v, 1'b0, STS_DATA, 4'd0, slot_len[s], slot_seq[s]);
		end
	endtask

	task automatic take_load(input logic [7:0] b);
		if (tx_len < PAYLOAD_BYTES)
			tx_buf[tx_len] = b;
		// one past full marks the message too long
		if (tx_len <= PAYLOAD_BYTES)
			tx_len = tx_len + 5'd1;
	endtask

	task automatic take_send(input logic [1:0] s);
		logic [4:0] n;
		logic [7:0] v;
		n = tx_len;
		tx_len = '0;
		if (s >= used_slots()) begin
			push_word(8'd0, 1'b0, STS_BAD_SLOT, 4'd0, 5'd0, 8'd0);
		end else if (n > PAYLOAD_BYTES) begin
			push_word(8'd0, 1'b0, STS_TOO_LONG, 4'd0, slot_len[s], slot_seq[s]);
		end else begin
			for (int k = 0; k < n; k++)
				slot_data[s][k] = tx_buf[k];
			slot_len[s] = n;
			slot_seq[s] = slot_seq[s] + 8'd1;
			for (int k = 0; k < n + MIN_PACKET; k++) begin
				if (k < 3)
					v = FRAME_HEAD[8*k +: 8];
				else if (k == 3)
					v = slot_seq[s];
				else if (k < MIN_PACKET)
					v = hash_q[s][8*(k-4) +: 8];
				else
					v = slot_data[s][k - MIN_PACKET];
				push_word(v, k == n + MIN_PACKET - 1, STS_DATA, 4'd0, n, slot_seq[s]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q = '0;
			for (int i = 0; i < HASH_REGS; i++)
				hash_q[i] = '0;
			clear_rx();
			tx_len = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_seq[i] = '0;
				slot_len[i] = '0;
			end
			awaited_words.delete();
			errs = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_ACTIVE)
					active_q = wr_data[2:0];
				else if (wr_index >= REG_HASH0 && wr_index < REG_HASH0 + HASH_REGS)
					hash_q[2'(wr_index - REG_HASH0)] = wr_data;
			end
			if (start && !busy) begin
				case (kind)
					KIND_RX:   take_rx(data_byte, packet_end);
					KIND_READ: take_read(slot, byte_index);
					KIND_LOAD: take_load(data_byte);
					default:   take_send(slot);
				endcase
			end
			if (strobe) begin
				got = {out_byte, frame_last, status, update_mask, stored_size, stored_count};
				if (awaited_words.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("bsf: unexpected word byte=%0d last=%0b status=%0d ",
							"mask=%h size=%0d count=%0d",
							got.value, got.last, got.sts, got.mask, got.len, got.count);
				end else begin
					want = awaited_words.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display("bsf: word mismatch: expected byte=%0d last=%0b ",
								"status=%0d mask=%h size=%0d count=%0d, ",
								want.value, want.last, want.sts, want.mask, want.len,
								want.count,
								"got byte=%0d last=%0b status=%0d mask=%h size=%0d count=%0d",
								got.value, got.last, got.sts, got.mask, got.len, got.count);
					end
				end
			end
			pending    <= awaited_words.size();
			fail_count <= errs;
		end
	end

endmodule

/* dv/tb_broadcast_signal_filter.sv */
// Testbench top of the broadcast signal filter: command stimulus, register writes and verdict.
module tb_broadcast_signal_filter;
	import bsf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	// longest silent work: packet end matching all slots with a full payload
	localparam int SETTLE      = 2 + (PAYLOAD_BYTES + 1) * SLOT_COUNT + 4;
	localparam int PHASE_ITEMS = 22;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        packet_end;
	logic [1:0]  slot;
	logic [4:0]  byte_index;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        frame_last;
	logic [2:0]  status;
	logic [3:0]  update_mask;
	logic [4:0]  stored_size;
	logic [7:0]  stored_count;

	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          items = 0;
	bit          idling = 1'b0;
	logic [31:0] hash_set [HASH_REGS];

	broadcast_signal_filter dut (.*);

	bsf_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one command word and hold it until taken
	task automatic put_item(input kind_t k, input logic [7:0] b, input logic eop,
			input logic [1:0] s, input logic [4:0] idx);
		@(negedge clk);
		if (idling && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		start      <= 1'b1;
		kind       <= k;
		data_byte  <= b;
		packet_end <= eop;
		slot       <= s;
		byte_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items++;
	endtask

	task automatic put_packet(input logic [7:0] seq, input logic [31:0] id, input int paylen);
		int total;
		logic [7:0] b;
		total = MIN_PACKET + paylen;
		for (int i = 0; i < total; i++) begin
			if (i < 3)
				b = head_byte(i[1:0]);
			else if (i == 3)
				b = seq;
			else if (i < MIN_PACKET)
				b = id[8*(i-4) +: 8];
			else
				b = 8'($urandom_range(0, 255));
			put_item(KIND_RX, b, i == total - 1, 2'($urandom_range(0, 3)),
				5'($urandom_range(0, 22)));
		end
	endtask

	// Broken packet: good header cut short, or random bytes
	task automatic put_junk();
		int n;
		bit good_head;
		logic [7:0] b;
		good_head = 1'($urandom_range(0, 1));
		n = good_head ? $urandom_range(1, 7) : $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			b = (good_head && i < 3) ? head_byte(i[1:0]) : 8'($urandom_range(0, 255));
			put_item(KIND_RX, b, i == n - 1, 2'($urandom_range(0, 3)),
				5'($urandom_range(0, 22)));
		end
	endtask

	task automatic send_payload(input int n, input logic [1:0] s);
		for (int i = 0; i < n; i++)
			put_item(KIND_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), 5'($urandom_range(0, 22)));
		put_item(KIND_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s,
			5'($urandom_range(0, 22)));
	endtask

	// Drop start and wait for the block to fall quiet
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic load_regs(input logic [2:0] act);
		drain();
		write_reg(REG_ACTIVE, {29'd0, act});
		for (int i = 0; i < HASH_REGS; i++)
			write_reg(REG_HASH0 + 3'(i), hash_set[i]);
	endtask

	function automatic logic [7:0] pick_seq();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 8'($urandom_range(0, 255));
		else if (r < 7)
			return 8'($urandom_range(193, 255));
		return 8'($urandom_range(0, 64));
	endfunction

	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return hash_set[2'($urandom_range(0, HASH_REGS - 1))];
	endfunction

	function automatic int pick_rx_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 6);
		else if (r < 9)
			return $urandom_range(7, PAYLOAD_BYTES);
		return $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 7);
	endfunction

	function automatic int pick_tx_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, 5);
		else if (r < 8)
			return $urandom_range(6, PAYLOAD_BYTES);
		else if (r < 9)
			return PAYLOAD_BYTES;
		return $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 3);
	endfunction

	task automatic random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			put_packet(pick_seq(), pick_id(), pick_rx_len());
		else if (r < 55)
			put_junk();
		else if (r < 70)
			put_item(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), 5'($urandom_range(0, 22)));
		else if (r < 92)
			send_payload(pick_tx_len(), 2'($urandom_range(0, 3)));
		else if (r < 96)
			put_item(KIND_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), 5'($urandom_range(0, 22)));
		else
			put_item(KIND_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), 5'($urandom_range(0, 22)));
	endtask

	initial begin
		logic [2:0] act;
		int target;
		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = KIND_RX;
		data_byte  = '0;
		packet_end = 1'b0;
		slot       = '0;
		byte_index = '0;
		wr_en      = 1'b0;
		wr_index   = '0;
		wr_data    = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed opening: slot 2 and 3 share a hash
		hash_set[0] = 32'h0000_0000;
		hash_set[1] = 32'hFFFF_FFFF;
		hash_set[2] = 32'h5A3C_96E1;
		hash_set[3] = 32'h5A3C_96E1;
		load_regs(3'd4);
		put_item(KIND_RX, 8'hFF, 1'b1, 2'd0, 5'd0);
		put_packet(8'd200, 32'hFFFF_FFFF, 1);
		// counter wraps from high to low
		put_packet(8'd10, 32'hFFFF_FFFF, 0);
		put_item(KIND_READ, 8'h00, 1'b0, 2'd1, 5'd0);
		send_payload(0, 2'd0);
		put_item(KIND_LOAD, 8'h00, 1'b1, 2'd3, 5'd22);
		put_item(KIND_LOAD, 8'hFF, 1'b0, 2'd0, 5'd0);
		put_item(KIND_SEND, 8'hFF, 1'b1, 2'd3, 5'd31 - 5'd9);
		put_item(KIND_READ, 8'hFF, 1'b1, 2'd3, 5'd1);
		put_item(KIND_READ, 8'h00, 1'b0, 2'd3, 5'd22);

		idling = 1'b1;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: act = 3'd4;
				1: act = 3'd0;
				2: act = 3'd7;
				3: act = 3'd2;
				4: act = 3'd1;
				5: act = 3'd3;
				default: act = 3'd4;
			endcase
			if (ph != 0) begin
				for (int i = 0; i < HASH_REGS; i++)
					hash_set[i] = $urandom;
				if ($urandom_range(0, 2) == 0)
					hash_set[2'($urandom_range(1, HASH_REGS - 1))] = hash_set[0];
				load_regs(act);
			end
			// overlong packet: position saturates and the payload is cut
			if (ph == 2)
				put_packet(pick_seq(), hash_set[0], 58);
			if (ph == 6)
				idling = 1'b0;
			target = items + PHASE_ITEMS;
			while (items < target)
				random_op();
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
